@@ rtl/saa_pkg.sv @@
// ----------------------------------------------------------------------------
// saa_pkg
// Shared types for the skyline atlas allocator: request and result beats and
// the per-beat control tag that travels with memory read data.
// ----------------------------------------------------------------------------
package saa_pkg;

  localparam int RECT_W = 9;
  localparam int POS_W  = 8;

  typedef struct packed {
    logic [RECT_W-1:0] rect_width;
    logic [RECT_W-1:0] rect_height;
  } req_t;

  typedef struct packed {
    logic             full_res;
    logic             sheet_index;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } res_t;

  // Control tag, registered so that it lines up with the registered read data of the memories
  typedef struct packed {
    logic vld;      // a column beat is in flight
    logic bwd;      // backward (suffix) pass, else forward (prefix) pass
    logic restart;  // column opens a new block of the running maximum
    logic eval;     // forward pass: a full window ends at this column
    logic first;    // forward pass: first column of a sheet
  } scan_op_t;

endpackage

@@ rtl/saa_ram.sv @@
// ----------------------------------------------------------------------------
// saa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module saa_ram #(
  parameter int  WIDTH = 9,
  parameter int  DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/saa_scan.sv @@
// ----------------------------------------------------------------------------
// saa_scan
// Window search datapath. Backward pass builds block suffix maxima into the
// scratch memory; forward pass combines them with block prefix maxima to get
// each window's maximum and keeps the leftmost lowest window.
// ----------------------------------------------------------------------------
module saa_scan
  import saa_pkg::*;
#(
  parameter int CW           = 8,
  parameter int HW           = 9,
  parameter int SHEET_HEIGHT = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  scan_op_t      op,
  input  logic [CW-1:0] col,
  input  logic [HW-1:0] sky_rd,
  input  logic [HW-1:0] suf_rd,
  output logic          suf_we,
  output logic [CW-1:0] suf_waddr,
  output logic [HW-1:0] suf_wdata,
  output logic [HW-1:0] best_h,
  output logic [CW-1:0] best_x,
  output logic          found
);

  logic [HW-1:0] run_r;
  logic [HW-1:0] best_r;
  logic [CW-1:0] bx_r;
  logic          found_r;

  logic [HW-1:0] run_sel;
  logic [HW-1:0] win;
  logic [HW-1:0] best_cur;
  logic          found_cur;
  logic          take;

  always_comb begin
    if (op.restart || (sky_rd > run_r)) begin
      run_sel = sky_rd;
    end else begin
      run_sel = run_r;
    end
    win       = (run_sel > suf_rd) ? run_sel : suf_rd;
    best_cur  = op.first ? HW'(SHEET_HEIGHT) : best_r;
    found_cur = op.first ? 1'b0 : found_r;
    take      = op.vld && !op.bwd && op.eval && (win < best_cur);
  end

  always_ff @(posedge clk) begin
    if (op.vld) begin
      run_r <= run_sel;
    end
    if (op.vld && !op.bwd) begin
      best_r <= take ? win : best_cur;
      if (take) begin
        bx_r <= col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (op.vld && !op.bwd) begin
      found_r <= found_cur | take;
    end
  end

  assign suf_we    = op.vld & op.bwd;
  assign suf_waddr = col;
  assign suf_wdata = run_sel;
  assign best_h    = best_r;
  assign best_x    = bx_r;
  assign found     = found_r;

endmodule

@@ rtl/skyline_atlas_allocator.sv @@
// ----------------------------------------------------------------------------
// skyline_atlas_allocator
// Skyline rectangle packer over NUM_SHEETS sheets. Per sheet, finds the
// leftmost start column whose window has the lowest skyline maximum, and
// raises that window when the rectangle fits under SHEET_HEIGHT.
//
//   channel  direction  handshake              beat
//   in_      input      in_valid / in_ready    req_t  (rect_width, rect_height)
//   out_     output     out_valid / out_ready  res_t  (full_res, sheet_index,
//                                                      pos_x, pos_y)
//
// Sequence: each sheet tried runs a backward pass over the columns, a
//   turnaround, a forward pass, a drain and a decide, one skyline read a
//   cycle. A placement then writes back its rect_width columns before the
//   result is handed to the output register.
// Reset: synchronous; a clearing pass zeroes all NUM_SHEETS*SHEET_WIDTH
//   skyline entries, with in_ready low until it ends.
// Stalls: a result waits in the output register while the next beat is taken;
//   a finished search holds until the output register frees up.
// ----------------------------------------------------------------------------
module skyline_atlas_allocator
  import saa_pkg::*;
#(
  parameter int NUM_SHEETS   = 2,
  parameter int SHEET_WIDTH  = 256,
  parameter int SHEET_HEIGHT = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  localparam int DEPTH = NUM_SHEETS * SHEET_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SHEET_WIDTH);
  localparam int CW1   = $clog2(SHEET_WIDTH + 1);
  localparam int HW    = $clog2(SHEET_HEIGHT + 1);
  localparam int SW    = (NUM_SHEETS > 1) ? $clog2(NUM_SHEETS) : 1;
  localparam int WXW   = (CW1 > RECT_W) ? CW1 : RECT_W;
  localparam int SUMW  = ((HW > RECT_W) ? HW : RECT_W) + 1;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_BWD    = 9'b000000100,
    S_TURN   = 9'b000001000,
    S_FWD    = 9'b000010000,
    S_DRAIN  = 9'b000100000,
    S_DECIDE = 9'b001000000,
    S_WRITE  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  // Sequencer state
  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [CW1-1:0]    w_r, w_nxt;
  logic [RECT_W-1:0] h_r, h_nxt;
  logic [SW-1:0]     sheet_r, sheet_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [CW-1:0]     c_r, c_nxt;       // column index, reused as write index
  logic [CW1-1:0]    cnt_r, cnt_nxt;   // place in block, one at its left column, w at its right
  res_t              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_data_r, out_data_nxt;
  scan_op_t          op_r, op_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic              out_load;

  // Memory ports
  logic              sky_we;
  logic [AW-1:0]     sky_waddr;
  logic [HW-1:0]     sky_wdata;
  logic [AW-1:0]     sky_raddr;
  logic [HW-1:0]     sky_rd;
  logic              suf_we;
  logic [CW-1:0]     suf_waddr;
  logic [HW-1:0]     suf_wdata;
  logic [CW-1:0]     suf_raddr;
  logic [HW-1:0]     suf_rd;

  // Search results
  logic [HW-1:0]     best_h;
  logic [CW-1:0]     best_x;
  logic              found;

  // Derived values
  logic [WXW-1:0]    w_ext;
  logic              bad_req;
  logic [CW1-1:0]    c_p1;
  logic              win_ok;
  logic [CW1-1:0]    x_ext;
  logic              at_block_top;
  logic [CW1-1:0]    cnt_step;
  logic [CW1-1:0]    cnt_up;
  logic [SUMW-1:0]   new_sum;
  logic              fits;
  logic [CW+7:0]     px_ext;
  logic [HW+7:0]     py_ext;

  always_comb begin
    w_ext        = WXW'(in_data.rect_width);
    bad_req      = (in_data.rect_width == '0) || (in_data.rect_height == '0) ||
                   (w_ext > WXW'(SHEET_WIDTH));
    c_p1         = CW1'(c_r) + CW1'(1);
    win_ok       = (c_p1 >= w_r);
    x_ext        = c_p1 - w_r;
    at_block_top = (cnt_r == w_r);
    cnt_step     = (cnt_r == CW1'(1)) ? w_r : (cnt_r - CW1'(1));
    cnt_up       = (cnt_r == w_r) ? CW1'(1) : (cnt_r + CW1'(1));
    new_sum      = SUMW'(best_h) + SUMW'(h_r);
    fits         = found && (new_sum <= SUMW'(SHEET_HEIGHT));
    px_ext       = (CW + 8)'(best_x);
    py_ext       = (HW + 8)'(best_h);
  end

  // Sequencer: clear, per-sheet backward/forward passes, decide, write back
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    sheet_nxt = sheet_r;
    base_nxt  = base_r;
    c_nxt     = c_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    op_nxt    = '0;
    col_nxt   = col_r;
    out_load  = 1'b0;
    in_ready  = 1'b0;
    sky_we    = 1'b0;
    sky_waddr = clr_r;
    sky_wdata = '0;
    sky_raddr = base_r + AW'(c_r);
    suf_raddr = x_ext[CW-1:0];

    case (state_r)
      S_CLEAR: begin
        // zero one skyline entry a cycle
        sky_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          w_nxt     = w_ext[CW1-1:0];
          h_nxt     = in_data.rect_height;
          sheet_nxt = '0;
          base_nxt  = '0;
          c_nxt     = CW'(SHEET_WIDTH - 1);
          cnt_nxt   = w_ext[CW1-1:0];
          if (bad_req) begin
            res_nxt          = '0;
            res_nxt.full_res = 1'b1;
            state_nxt        = S_DONE;
          end else begin
            state_nxt = S_BWD;
          end
        end
      end

      S_BWD: begin
        // walk right to left; blocks end at the right edge, every w columns
        op_nxt.vld     = 1'b1;
        op_nxt.bwd     = 1'b1;
        op_nxt.restart = at_block_top;
        col_nxt        = c_r;
        cnt_nxt        = cnt_step;
        c_nxt          = c_r - CW'(1);
        if (c_r == '0) begin
          // keep column 0's place in its block for the forward pass
          cnt_nxt   = cnt_r;
          c_nxt     = '0;
          state_nxt = S_TURN;
        end
      end

      S_TURN: begin
        // let the last suffix write land before the forward reads
        state_nxt = S_FWD;
      end

      S_FWD: begin
        // walk left to right; a block opens at column 0 and where its count is one
        op_nxt.vld     = 1'b1;
        op_nxt.restart = (c_r == '0) || (cnt_r == CW1'(1));
        op_nxt.eval    = win_ok;
        op_nxt.first   = (c_r == '0);
        col_nxt        = x_ext[CW-1:0];
        cnt_nxt        = cnt_up;
        c_nxt          = c_r + CW'(1);
        if (c_r == CW'(SHEET_WIDTH - 1)) begin
          c_nxt     = '0;
          state_nxt = S_DRAIN;
        end
      end

      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        if (fits) begin
          c_nxt     = '0;
          state_nxt = S_WRITE;
        end else if (sheet_r == SW'(NUM_SHEETS - 1)) begin
          res_nxt          = '0;
          res_nxt.full_res = 1'b1;
          state_nxt        = S_DONE;
        end else begin
          // advance to the next sheet
          sheet_nxt = sheet_r + SW'(1);
          base_nxt  = base_r + AW'(SHEET_WIDTH);
          c_nxt     = CW'(SHEET_WIDTH - 1);
          cnt_nxt   = w_r;
          state_nxt = S_BWD;
        end
      end

      S_WRITE: begin
        // raise the chosen window, one column a cycle
        sky_we    = 1'b1;
        sky_waddr = base_r + AW'(best_x) + AW'(c_r);
        sky_wdata = new_sum[HW-1:0];
        c_nxt     = c_r + CW'(1);
        if (c_p1 == w_r) begin
          res_nxt.full_res    = 1'b0;
          res_nxt.sheet_index = sheet_r[0];
          res_nxt.pos_x       = px_ext[POS_W-1:0];
          res_nxt.pos_y       = py_ext[POS_W-1:0];
          state_nxt           = S_DONE;
        end
      end

      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_data_nxt = out_load ? res_r : out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      op_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    sheet_r    <= sheet_nxt;
    base_r     <= base_nxt;
    c_r        <= c_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    col_r      <= col_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Skyline: one height per column, all sheets back to back
  saa_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_sky_ram (
    .clk   (clk),
    .we    (sky_we),
    .waddr (sky_waddr),
    .wdata (sky_wdata),
    .raddr (sky_raddr),
    .rdata (sky_rd)
  );

  // Scratch: block suffix maxima of the sheet under search
  saa_ram #(
    .WIDTH (HW),
    .DEPTH (SHEET_WIDTH)
  ) u_suf_ram (
    .clk   (clk),
    .we    (suf_we),
    .waddr (suf_waddr),
    .wdata (suf_wdata),
    .raddr (suf_raddr),
    .rdata (suf_rd)
  );

  saa_scan #(
    .CW           (CW),
    .HW           (HW),
    .SHEET_HEIGHT (SHEET_HEIGHT)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op_r),
    .col       (col_r),
    .sky_rd    (sky_rd),
    .suf_rd    (suf_rd),
    .suf_we    (suf_we),
    .suf_waddr (suf_waddr),
    .suf_wdata (suf_wdata),
    .best_h    (best_h),
    .best_x    (best_x),
    .found     (found)
  );

endmodule
